// File: rtl/sovp_pkg.sv
// Package of the sound output volume path: constants, queue entry type, gain table.
// Used by every other file of the block through scoped names.
package sovp_pkg;

  // Field widths.
  localparam int SampleW = 16;
  localparam int AttW    = 6;
  localparam int GainW   = 17;
  localparam int ProdW   = SampleW + GainW;
  localparam int SumW    = SampleW + 2;

  // Largest attenuation a volume commit may load.
  localparam logic [AttW-1:0] MaxAtten = 6'd43;

  // Output mode register codes.
  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_REPEAT    = 2'd1,
    MODE_ZERO_FILL = 2'd2,
    MODE_DROP      = 2'd3
  } out_mode_e;

  // Input action codes.
  localparam logic ActControl = 1'b0;
  localparam logic ActFrame   = 1'b1;

  // Control byte bit positions.
  localparam int CtlMute    = 4;
  localparam int CtlLowpass = 3;
  localparam int CtlClock   = 2;
  localparam int CtlData    = 1;
  localparam int CtlStrobe  = 0;

  // Serial volume word layout, counted in received bits.
  localparam logic [3:0] ChanFirstBit = 4'd3;
  localparam logic [3:0] VolFirstBit  = 4'd5;
  localparam logic [3:0] WordBits     = 4'd11;
  localparam logic [3:0] CountMax     = 4'd15;

  // Queue between front and back.
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // One accepted frame together with the settings that were live when it came in.
  typedef struct packed {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    logic                      end_of_buffer;
    logic                      dbl;
    logic                      zero_fill;
    logic                      lowpass;
    logic [AttW-1:0]           left_att;
    logic [AttW-1:0]           right_att;
  } entry_t;

  // Q2.15 logarithmic attenuation gains.
  localparam logic signed [GainW-1:0] GainTable [64] = '{
    17'sd32768, 17'sd32768, 17'sd26729, 17'sd23197, 17'sd20690, 17'sd18746, 17'sd17158,
    17'sd15815, 17'sd14652, 17'sd13625, 17'sd12708, 17'sd11877, 17'sd11119, 17'sd10422,
    17'sd9776, 17'sd9175, 17'sd8613, 17'sd8085, 17'sd7587, 17'sd7116, 17'sd6669,
    17'sd6244, 17'sd5839, 17'sd5451, 17'sd5080, 17'sd4725, 17'sd4383, 17'sd4054,
    17'sd3737, 17'sd3432, 17'sd3136, 17'sd2851, 17'sd2574, 17'sd2306, 17'sd2046,
    17'sd1793, 17'sd1548, 17'sd1309, 17'sd1077, 17'sd851, 17'sd630, 17'sd415,
    17'sd205, 17'sd0, -17'sd200, -17'sd396, -17'sd588, -17'sd775,
    -17'sd958, -17'sd1138, -17'sd1314, -17'sd1487, -17'sd1656, -17'sd1822,
    -17'sd1984, -17'sd2144, -17'sd2301, -17'sd2456, -17'sd2607, -17'sd2756,
    -17'sd2902, -17'sd3046, -17'sd3188, -17'sd3327
  };

  function automatic logic signed [GainW-1:0] gain_lookup(input logic [AttW-1:0] att);
    return GainTable[att];
  endfunction

endpackage

// File: rtl/sovp_if.sv
// Handshake channels of the sound output volume path: input, result and config write.
// Depends on sovp_pkg for widths.
interface sovp_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic [7:0]                         control_byte;
  logic signed [sovp_pkg::SampleW-1:0] left_sample;
  logic signed [sovp_pkg::SampleW-1:0] right_sample;
  logic                               end_of_buffer;

  modport source (output valid, action, control_byte, left_sample, right_sample,
                  end_of_buffer, input ready);
  modport sink (input valid, action, control_byte, left_sample, right_sample,
                end_of_buffer, output ready);
endinterface

interface sovp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sovp_pkg::SampleW-1:0] left_out;
  logic signed [sovp_pkg::SampleW-1:0] right_out;
  logic                               last_of_run;
  logic                               buffer_end;

  modport source (output valid, left_out, right_out, last_of_run, buffer_end,
                  input ready);
  modport sink (input valid, left_out, right_out, last_of_run, buffer_end,
                output ready);
endinterface

interface sovp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/sound_output_volume_path_unit.sv
// Top level of the stereo sound output volume path.
// Depends on sovp_pkg, sovp_if, sovp_fifo, sovp_front and sovp_back.
//
// Usage: in_ch carries requests: a control byte write (mute, lowpass and the
// clock/data/strobe lines of the serial volume interface) or a stereo frame.
// cfg_ch writes the two-bit output mode; write it only while the block is idle.
// out_ch delivers processed frames with last_of_run and buffer_end flags.
// A frame gives one result in normal mode, two in the doubled modes, and none
// when muted or in the dropping mode. Control writes give no result.
// Throughput: one request per cycle in normal mode while results are taken; a doubled
// frame stays queued until its entry has expanded into two results in the back end.
// A frame's path: the queue is written at the edge that accepts it, then filter and
// gain lookup, multiply and the output register follow as registered stages in that
// order, each of which can be held by a stall on out_ch.
// A four-entry queue parts the front from the back; in_ch.ready falls only when it
// is full, so control writes stall too while the receiver holds off.
// Reset clears mode, volume settings, filter history and all valid flags; the
// block accepts requests in the first cycle after reset.
module sound_output_volume_path_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  sovp_in_if.sink   in_ch,
  sovp_cfg_if.sink  cfg_ch,
  sovp_out_if.source out_ch
);

  logic             fifo_full, fifo_empty, push, pop;
  sovp_pkg::entry_t push_data, pop_data;

  sovp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cfg_ch      (cfg_ch),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sovp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (fifo_empty)
  );

  sovp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .entry_i      (pop_data),
    .pop_o        (pop),
    .out_ch       (out_ch)
  );

  // The queue cannot be full and empty at once.
  a_fifo_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_full && fifo_empty))
    else $error("queue reports full and empty together");

  // Only the final result of a frame carries the buffer end mark.
  a_eob_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.buffer_end |-> out_ch.last_of_run)
    else $error("buffer end on a result that is not the last of its frame");

  // A frame only leaves the queue when the back end takes it.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_empty)
    else $error("queue popped while empty");

  // Nothing can come out the cycle after reset, since the pipeline is empty.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_ch.valid)
    else $error("result shown right after reset");

endmodule

// File: rtl/sovp_fifo.sv
// Small flop-based queue of frame entries between the front and the back.
// Depends on sovp_pkg for the entry type and depth.
module sovp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sovp_pkg::entry_t  push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output sovp_pkg::entry_t  pop_data_o,
  output logic              empty_o
);

  sovp_pkg::entry_t                  mem_q [sovp_pkg::FifoDepth];
  logic [sovp_pkg::FifoPtrW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [sovp_pkg::FifoCntW-1:0]     cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign full_o     = (cnt_q == sovp_pkg::FifoCntW'(sovp_pkg::FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/sovp_front.sv
// Front of the volume path: takes requests, runs the serial volume interface and the
// mode register, and queues frames to be played. Depends on sovp_pkg and sovp_if.
module sovp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  sovp_in_if.sink          in_ch,
  sovp_cfg_if.sink         cfg_ch,
  input  logic             fifo_full_i,
  output logic             push_o,
  output sovp_pkg::entry_t push_data_o
);

  logic [1:0]                  mode_q;
  logic                        prev_clk_q, prev_clk_d;
  logic [3:0]                  cnt_q, cnt_d;
  logic [1:0]                  chan_q, chan_d;
  logic [sovp_pkg::AttW-1:0]   vol_q, vol_d;
  logic [sovp_pkg::AttW-1:0]   latt_q, latt_d, ratt_q, ratt_d;
  logic                        mute_q, mute_d, lp_q, lp_d;
  logic [sovp_pkg::AttW-1:0]   clamped;
  logic                        accept, ctl_write, ser_clk, ser_bit;

  assign in_ch.ready  = !fifo_full_i;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign ctl_write    = accept && (in_ch.action == sovp_pkg::ActControl);
  assign ser_clk      = in_ch.control_byte[sovp_pkg::CtlClock];
  assign ser_bit      = in_ch.control_byte[sovp_pkg::CtlData];
  assign clamped      = (vol_q > sovp_pkg::MaxAtten) ? sovp_pkg::MaxAtten : vol_q;

  // Serial volume interface and flag update on a control write request.
  always_comb begin
    prev_clk_d = prev_clk_q;
    cnt_d      = cnt_q;
    chan_d     = chan_q;
    vol_d      = vol_q;
    latt_d     = latt_q;
    ratt_d     = ratt_q;
    mute_d     = mute_q;
    lp_d       = lp_q;
    if (ctl_write) begin
      mute_d     = in_ch.control_byte[sovp_pkg::CtlMute];
      lp_d       = in_ch.control_byte[sovp_pkg::CtlLowpass];
      prev_clk_d = ser_clk;
      if (in_ch.control_byte[sovp_pkg::CtlStrobe]) begin
        if (cnt_q == sovp_pkg::WordBits) begin
          if (chan_q[0]) latt_d = clamped;
          if (chan_q[1]) ratt_d = clamped;
        end
      end else if (ser_clk && !prev_clk_q) begin
        if (cnt_q >= sovp_pkg::ChanFirstBit && cnt_q < sovp_pkg::VolFirstBit) begin
          chan_d = {chan_q[0], ser_bit};
        end else if (cnt_q >= sovp_pkg::VolFirstBit && cnt_q < sovp_pkg::WordBits) begin
          vol_d = {vol_q[sovp_pkg::AttW-2:0], ser_bit};
        end
        if (cnt_q < sovp_pkg::CountMax) begin
          cnt_d = cnt_q + 1'b1;
        end
      end else if (ser_clk == prev_clk_q) begin
        cnt_d  = '0;
        chan_d = '0;
        vol_d  = '0;
      end
    end
  end

  // A frame is queued unless muted or the mode drops frames.
  always_comb begin
    push_o = accept && (in_ch.action == sovp_pkg::ActFrame) && !mute_q
             && (mode_q != sovp_pkg::MODE_DROP);
    push_data_o.left          = in_ch.left_sample;
    push_data_o.right         = in_ch.right_sample;
    push_data_o.end_of_buffer = in_ch.end_of_buffer;
    push_data_o.dbl           = (mode_q != sovp_pkg::MODE_NORMAL);
    push_data_o.zero_fill     = (mode_q == sovp_pkg::MODE_ZERO_FILL);
    push_data_o.lowpass       = lp_q;
    push_data_o.left_att      = latt_q;
    push_data_o.right_att     = ratt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= sovp_pkg::MODE_NORMAL;
      prev_clk_q <= 1'b0;
      cnt_q      <= '0;
      chan_q     <= '0;
      vol_q      <= '0;
      latt_q     <= '0;
      ratt_q     <= '0;
      mute_q     <= 1'b0;
      lp_q       <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        mode_q <= cfg_ch.data;
      end
      prev_clk_q <= prev_clk_d;
      cnt_q      <= cnt_d;
      chan_q     <= chan_d;
      vol_q      <= vol_d;
      latt_q     <= latt_d;
      ratt_q     <= ratt_d;
      mute_q     <= mute_d;
      lp_q       <= lp_d;
    end
  end

endmodule

// File: rtl/sovp_back.sv
// Back of the volume path: expands queued frames into results, runs the lowpass
// filter and the gain multiply in a three-register pipeline. Depends on sovp_pkg, sovp_if.
module sovp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fifo_empty_i,
  input  sovp_pkg::entry_t entry_i,
  output logic             pop_o,
  sovp_out_if.source       out_ch
);

  localparam int SW = sovp_pkg::SampleW;
  localparam int PW = sovp_pkg::ProdW;

  logic                         sub_q, sub_d;
  logic signed [SW-1:0]         lh0_q, lh1_q, rh0_q, rh1_q;
  logic signed [SW-1:0]         xl, xr, fl, fr;
  logic signed [sovp_pkg::SumW-1:0] suml, sumr;
  logic                         last_run;

  // Stage A: filtered samples and gains.
  logic                         a_valid_q;
  logic signed [SW-1:0]         a_l_q, a_r_q;
  logic signed [sovp_pkg::GainW-1:0] a_gl_q, a_gr_q;
  logic                         a_last_q, a_eob_q;
  // Stage B: products.
  logic                         b_valid_q;
  logic signed [PW-1:0]         b_pl_q, b_pr_q;
  logic                         b_last_q, b_eob_q;
  // Output register.
  logic                         o_valid_q;
  logic signed [PW-1:0]         bias_l, bias_r;

  logic o_free, b_free, a_free, a_load;

  assign o_free = !o_valid_q || out_ch.ready;
  assign b_free = !b_valid_q || o_free;
  assign a_free = !a_valid_q || b_free;
  assign a_load = !fifo_empty_i && a_free;

  // Second copy of a doubled frame is the same frame or silence.
  assign xl       = (sub_q && entry_i.zero_fill) ? '0 : entry_i.left;
  assign xr       = (sub_q && entry_i.zero_fill) ? '0 : entry_i.right;
  assign last_run = !entry_i.dbl || sub_q;
  assign pop_o    = a_load && last_run;
  assign sub_d    = a_load ? !last_run : sub_q;

  // 1-2-1 lowpass, floor of the quarter sum.
  always_comb begin
    suml = sovp_pkg::SumW'(lh0_q) + (sovp_pkg::SumW'(lh1_q) <<< 1) + sovp_pkg::SumW'(xl);
    sumr = sovp_pkg::SumW'(rh0_q) + (sovp_pkg::SumW'(rh1_q) <<< 1) + sovp_pkg::SumW'(xr);
    fl   = entry_i.lowpass ? suml[sovp_pkg::SumW-1:2] : xl;
    fr   = entry_i.lowpass ? sumr[sovp_pkg::SumW-1:2] : xr;
  end

  // Truncation toward zero of the product with the Q2.15 gain.
  assign bias_l = b_pl_q + (b_pl_q[PW-1] ? PW'(32767) : '0);
  assign bias_r = b_pr_q + (b_pr_q[PW-1] ? PW'(32767) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q     <= 1'b0;
      lh0_q     <= '0;
      lh1_q     <= '0;
      rh0_q     <= '0;
      rh1_q     <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
      if (a_load && entry_i.lowpass) begin
        lh0_q <= lh1_q;
        lh1_q <= xl;
        rh0_q <= rh1_q;
        rh1_q <= xr;
      end
      if (a_free) a_valid_q <= !fifo_empty_i;
      if (b_free) b_valid_q <= a_valid_q;
      if (o_free) o_valid_q <= b_valid_q;
    end
  end

  // Payload registers of the pipeline.
  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_l_q    <= fl;
      a_r_q    <= fr;
      a_gl_q   <= sovp_pkg::gain_lookup(entry_i.left_att);
      a_gr_q   <= sovp_pkg::gain_lookup(entry_i.right_att);
      a_last_q <= last_run;
      a_eob_q  <= last_run && entry_i.end_of_buffer;
    end
    if (b_free && a_valid_q) begin
      b_pl_q   <= PW'(a_l_q) * PW'(a_gl_q);
      b_pr_q   <= PW'(a_r_q) * PW'(a_gr_q);
      b_last_q <= a_last_q;
      b_eob_q  <= a_eob_q;
    end
    if (o_free && b_valid_q) begin
      out_ch.left_out    <= bias_l[SW+14:15];
      out_ch.right_out   <= bias_r[SW+14:15];
      out_ch.last_of_run <= b_last_q;
      out_ch.buffer_end  <= b_eob_q;
    end
  end

  assign out_ch.valid = o_valid_q;

endmodule

// File: verif/sound_output_volume_path_unit_test.sv
// Self-checking testbench for the stereo sound output volume path.
// Needs sovp_pkg, the sovp_if channel interfaces and the sound_output_volume_path_unit RTL.
`timescale 1ns / 100ps

module sound_output_volume_path_unit_test;

  localparam int CycleLimit = 500000;

  // Q2.15 gain for each attenuation that a commit can load (0 to 43).
  localparam int GainQ15 [44] = '{
    32768, 32768, 26729, 23197, 20690, 18746, 17158, 15815,
    14652, 13625, 12708, 11877, 11119, 10422, 9776, 9175,
    8613, 8085, 7587, 7116, 6669, 6244, 5839, 5451,
    5080, 4725, 4383, 4054, 3737, 3432, 3136, 2851,
    2574, 2306, 2046, 1793, 1548, 1309, 1077, 851,
    630, 415, 205, 0
  };

  // Output mode of each random phase; both ends of the range come up twice.
  localparam sovp_pkg::out_mode_e PhaseModes [8] = '{
    sovp_pkg::MODE_REPEAT, sovp_pkg::MODE_ZERO_FILL, sovp_pkg::MODE_DROP,
    sovp_pkg::MODE_NORMAL, sovp_pkg::MODE_ZERO_FILL, sovp_pkg::MODE_REPEAT,
    sovp_pkg::MODE_DROP, sovp_pkg::MODE_NORMAL
  };

  typedef struct {
    logic signed [sovp_pkg::SampleW-1:0] left;
    logic signed [sovp_pkg::SampleW-1:0] right;
    logic                                last;
    logic                                eob;
  } frame_result_t;

  // Tracks volume, filter and mode state, and holds the frames still owed by the block.
  class volume_path_scoreboard;
    sovp_pkg::out_mode_e                 mode;
    bit                                  prev_clk;
    bit [3:0]                            bit_cnt;
    bit [1:0]                            chan_sel;
    bit [sovp_pkg::AttW-1:0]             vol_acc;
    bit [sovp_pkg::AttW-1:0]             att_l;
    bit [sovp_pkg::AttW-1:0]             att_r;
    bit                                  muted;
    bit                                  lp_en;
    logic signed [sovp_pkg::SampleW-1:0] hist_l [2];
    logic signed [sovp_pkg::SampleW-1:0] hist_r [2];
    frame_result_t                       owed_frames [$];
    int                                  errors;
    int                                  checked;

    function new();
      mode = sovp_pkg::MODE_NORMAL;
      hist_l = '{16'sd0, 16'sd0};
      hist_r = '{16'sd0, 16'sd0};
    endfunction

    function int pending();
      return owed_frames.size();
    endfunction

    task report(input string msg);
      if (errors < 40) $display("mismatch at result %0d: %s", checked, msg);
      errors++;
    endtask

    // 1-2-1 smoothing, floor of the sum over four.
    function logic signed [sovp_pkg::SampleW-1:0] smooth(
        input logic signed [sovp_pkg::SampleW-1:0] h0,
        input logic signed [sovp_pkg::SampleW-1:0] h1,
        input logic signed [sovp_pkg::SampleW-1:0] x);
      int acc;
      acc = int'(h0) + 2 * int'(h1) + int'(x);
      return sovp_pkg::SampleW'(acc >>> 2);
    endfunction

    // Gain product, truncated toward zero.
    function logic signed [sovp_pkg::SampleW-1:0] attenuate(
        input logic signed [sovp_pkg::SampleW-1:0] s,
        input bit [sovp_pkg::AttW-1:0] a);
      longint prod;
      prod = longint'(s) * longint'(GainQ15[a]);
      if (prod < 0) prod = -((-prod) >>> 15);
      else prod = prod >>> 15;
      return sovp_pkg::SampleW'(prod);
    endfunction

    function void push_frame(input logic signed [sovp_pkg::SampleW-1:0] l,
                             input logic signed [sovp_pkg::SampleW-1:0] r,
                             input logic last, input logic eob);
      frame_result_t res;
      if (lp_en) begin
        res.left = smooth(hist_l[0], hist_l[1], l);
        res.right = smooth(hist_r[0], hist_r[1], r);
        hist_l[0] = hist_l[1];
        hist_l[1] = l;
        hist_r[0] = hist_r[1];
        hist_r[1] = r;
      end else begin
        res.left = l;
        res.right = r;
      end
      res.left = attenuate(res.left, att_l);
      res.right = attenuate(res.right, att_r);
      res.last = last;
      res.eob = eob;
      owed_frames.push_back(res);
    endfunction

    // Flags, then the serial volume interface: strobe commits, a rising clock shifts,
    // an unchanged clock level clears the shifter.
    function void control_write(input logic [7:0] cb);
      bit clk_b;
      bit dat;
      bit [sovp_pkg::AttW-1:0] vol;
      clk_b = cb[sovp_pkg::CtlClock];
      dat = cb[sovp_pkg::CtlData];
      muted = cb[sovp_pkg::CtlMute];
      lp_en = cb[sovp_pkg::CtlLowpass];
      if (cb[sovp_pkg::CtlStrobe]) begin
        if (bit_cnt == sovp_pkg::WordBits) begin
          vol = (vol_acc > sovp_pkg::MaxAtten) ? sovp_pkg::MaxAtten : vol_acc;
          if (chan_sel[0]) att_l = vol;
          if (chan_sel[1]) att_r = vol;
        end
      end else if (clk_b && !prev_clk) begin
        if (bit_cnt >= sovp_pkg::ChanFirstBit && bit_cnt < sovp_pkg::VolFirstBit)
          chan_sel = {chan_sel[0], dat};
        else if (bit_cnt >= sovp_pkg::VolFirstBit && bit_cnt < sovp_pkg::WordBits)
          vol_acc = {vol_acc[sovp_pkg::AttW-2:0], dat};
        if (bit_cnt < sovp_pkg::CountMax) bit_cnt++;
      end else if (clk_b == prev_clk) begin
        bit_cnt = '0;
        chan_sel = '0;
        vol_acc = '0;
      end
      prev_clk = clk_b;
    endfunction

    // Returns how many results the accepted request owes.
    function int note_request(input logic act, input logic [7:0] cb,
                              input logic signed [sovp_pkg::SampleW-1:0] l,
                              input logic signed [sovp_pkg::SampleW-1:0] r,
                              input logic eob);
      if (act == sovp_pkg::ActControl) begin
        control_write(cb);
        return 0;
      end
      if (muted || mode == sovp_pkg::MODE_DROP) return 0;
      if (mode == sovp_pkg::MODE_NORMAL) begin
        push_frame(l, r, 1'b1, eob);
        return 1;
      end
      push_frame(l, r, 1'b0, 1'b0);
      if (mode == sovp_pkg::MODE_REPEAT) push_frame(l, r, 1'b1, eob);
      else push_frame('0, '0, 1'b1, eob);
      return 2;
    endfunction

    task check_frame(input logic signed [sovp_pkg::SampleW-1:0] l,
                     input logic signed [sovp_pkg::SampleW-1:0] r,
                     input logic last, input logic eob);
      frame_result_t exp_res;
      checked++;
      if (owed_frames.size() == 0) begin
        report($sformatf("unexpected result left %0d right %0d", l, r));
        return;
      end
      exp_res = owed_frames.pop_front();
      if (l !== exp_res.left)
        report($sformatf("left_out %0d, wanted %0d", l, exp_res.left));
      if (r !== exp_res.right)
        report($sformatf("right_out %0d, wanted %0d", r, exp_res.right));
      if (last !== exp_res.last)
        report($sformatf("last_of_run %b, wanted %b", last, exp_res.last));
      if (eob !== exp_res.eob)
        report($sformatf("buffer_end %b, wanted %b", eob, exp_res.eob));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   cycles = 0;
  int   items_sent = 0;
  bit   calm_in = 1'b0;
  bit   calm_out = 1'b0;
  volume_path_scoreboard sb;

  sovp_in_if  in_ch ();
  sovp_cfg_if cfg_ch ();
  sovp_out_if out_ch ();

  sound_output_volume_path_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  // Mostly random samples, with a good share of extremes and values near zero.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Control byte with the given lines; the unused top bits are random.
  function automatic logic [7:0] make_ctl(input bit mute, input bit lp, input bit clk_b,
                                          input bit dat, input bit stb);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255)) & 8'hE0;
    b[sovp_pkg::CtlMute] = mute;
    b[sovp_pkg::CtlLowpass] = lp;
    b[sovp_pkg::CtlClock] = clk_b;
    b[sovp_pkg::CtlData] = dat;
    b[sovp_pkg::CtlStrobe] = stb;
    return b;
  endfunction

  // Drives one request after a random gap and waits until it is taken.
  task automatic send_req(input logic act, input logic [7:0] cb, input logic [15:0] ls,
                          input logic [15:0] rs, input logic eob);
    int gap;
    gap = draw_gap(calm_in);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.control_byte <= cb;
    in_ch.left_sample <= ls;
    in_ch.right_sample <= rs;
    in_ch.end_of_buffer <= eob;
    do @(posedge clk_i); while (!in_ch.ready);
    void'(sb.note_request(act, cb, ls, rs, eob));
    items_sent++;
  endtask

  task automatic send_ctl(input logic [7:0] cb);
    send_req(sovp_pkg::ActControl, cb, 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_frame(input logic [15:0] ls, input logic [15:0] rs, input logic eob);
    send_req(sovp_pkg::ActFrame, 8'($urandom_range(0, 255)), ls, rs, eob);
  endtask

  // Serial volume word: three ignored bits, two channel bits, six volume bits, MSB first,
  // each clocked by a rise and a fall, then a strobe. Frames may slip in between bits.
  task automatic send_volume(input bit [1:0] chan, input bit [sovp_pkg::AttW-1:0] vol,
                             input bit lp, input bit mute, input int nbits);
    logic [10:0] word;
    bit b;
    word = {3'($urandom_range(0, 7)), chan, vol};
    send_ctl(make_ctl(mute, lp, 1'b0, 1'b0, 1'b0));
    for (int i = 0; i < nbits; i++) begin
      b = (i < 11) ? word[10-i] : 1'($urandom_range(0, 1));
      send_ctl(make_ctl(mute, lp, 1'b1, b, 1'b0));
      if ($urandom_range(0, 11) == 0)
        send_frame(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
      send_ctl(make_ctl(mute, lp, 1'b0, b, 1'b0));
    end
    send_ctl(make_ctl(mute, lp, 1'b0, 1'b0, 1'b1));
  endtask

  // Mode writes happen only once the block has drained.
  task automatic write_mode(input sovp_pkg::out_mode_e m);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= m;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.mode = m;
  endtask

  // One random request or sequence: mostly frames, with flag writes, noise bytes and
  // volume transfers that are sometimes cut short or run long.
  task automatic random_step();
    int pick;
    int nbits;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      send_frame(pick_sample(), pick_sample(), 1'($urandom_range(0, 3) == 0));
    end else if (pick < 74) begin
      case ($urandom_range(0, 9))
        0: nbits = $urandom_range(0, 10);
        1: nbits = $urandom_range(12, 17);
        default: nbits = 11;
      endcase
      send_volume(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 9) == 0), nbits);
    end else if (pick < 90) begin
      send_ctl(make_ctl(1'($urandom_range(0, 4) == 0), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0));
    end else begin
      send_ctl(8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: random stalls before each result, checked on acceptance.
  initial begin
    int gap;
    int taken;
    taken = 0;
    @(posedge clk_i);
    forever begin
      gap = draw_gap(calm_out);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      sb.check_frame(out_ch.left_out, out_ch.right_out, out_ch.last_of_run, out_ch.buffer_end);
      taken++;
      if (taken % 37 == 0) calm_out = ($urandom_range(0, 3) == 0);
    end
  end

  // Request side and run control.
  initial begin
    int target;
    int picks;
    sb = new();
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= sovp_pkg::ActControl;
    in_ch.control_byte <= '0;
    in_ch.left_sample <= '0;
    in_ch.right_sample <= '0;
    in_ch.end_of_buffer <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= sovp_pkg::MODE_NORMAL;
    out_ch.ready <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extremes at unity gain, then through the lowpass filter.
    send_frame(16'h7FFF, 16'h8000, 1'b1);
    send_frame(16'h8000, 16'h7FFF, 1'b0);
    send_frame(16'h0000, 16'hFFFF, 1'b1);
    send_ctl(8'h08);
    send_frame(16'h7FFF, 16'h7FFF, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b1);
    send_frame(16'h8000, 16'h8000, 1'b0);
    send_frame(16'hFFFF, 16'h0001, 1'b1);
    // Mute drops a frame; a strobe with nothing shifted in changes no volume.
    send_ctl(8'h10);
    send_frame(16'h1234, 16'hEDCC, 1'b1);
    send_ctl(8'h00);
    send_ctl(8'hFF);
    send_frame(16'h4321, 16'hBCDF, 1'b0);
    send_ctl(8'hE4);
    send_frame(16'h5A5A, 16'hA5A5, 1'b1);

    for (int p = 0; p < 8; p++) begin
      write_mode(PhaseModes[p]);
      calm_in = 1'b0;
      // The first transfer loads the top volume code on both channels, which clamps.
      if (p == 0) send_volume(2'b11, 6'd63, 1'b0, 1'b0, 11);
      else send_volume(2'($urandom_range(1, 3)), 6'($urandom_range(0, 63)),
                       1'($urandom_range(0, 1)), 1'b0, 11);
      target = items_sent + ((PhaseModes[p] == sovp_pkg::MODE_DROP) ? 50 : 225);
      picks = 0;
      while (items_sent < target) begin
        random_step();
        picks++;
        if (picks % 29 == 0) calm_in = ($urandom_range(0, 4) == 0);
      end
    end

    // Drain and let the pipeline settle before the verdict.
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
